// ===== hw/rtl/tap_dance_key_sequencer_defines.svh =====
// Assertion macros shared by the tap-dance sequencer RTL.
// Used by tds_ctrl and tds_dp; each module provides clock and reset.
`ifndef TAP_DANCE_KEY_SEQUENCER_DEFINES_SVH
`define TAP_DANCE_KEY_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TDS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tap dance sequencer check failed");
// next-cycle implication
`define TDS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tap dance sequencer check failed");
`else
`define TDS_ASSERT_IMPL(lbl, ante, cons)
`define TDS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/tds_pkg.sv =====
// Shared types and constants of the tap-dance key sequencer.
// Used by tds_ctrl, tds_dp and tap_dance_key_sequencer; no dependencies.
`default_nettype none

package tds_pkg;

   // field widths
   localparam int KEY_W  = 4;
   localparam int TC_W   = 8;
   localparam int POS_W  = 8;
   localparam int TIME_W = 32;
   localparam int TMO_W  = 16;
   localparam int ACT_W  = 3;

   localparam logic [TMO_W-1:0] TMO_RESET = 16'd200;

   // request tdata layout, lowest bit first
   localparam int IN_DATA_W  = 64;
   localparam int NOW_LSB    = 0;
   localparam int TD_BIT     = 32;
   localparam int KEY_LSB    = 33;
   localparam int ROW_LSB    = 37;
   localparam int COL_LSB    = 45;
   localparam int IS_BIT     = 53;
   localparam int WAS_BIT    = 54;
   localparam int INJ_BIT    = 55;
   localparam int MASKED_BIT = 56;

   // response tdata width
   localparam int OUT_DATA_W = 32;

   // action codes carried on rsp_tuser
   typedef enum logic [ACT_W-1:0] {
      ACT_TAP       = 3'd0,
      ACT_HOLD      = 3'd1,
      ACT_INTERRUPT = 3'd2,
      ACT_TIMEOUT   = 3'd3,
      ACT_RELEASE   = 3'd4,
      ACT_MASK      = 3'd5,
      ACT_VERDICT   = 3'd6
   } act_type;

   // tap count memory read address select
   typedef enum logic [1:0] {
      RD_IDX  = 2'd0,
      RD_ACT  = 2'd1,
      RD_SCAN = 2'd2
   } rd_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;
      rd_sel_type rd_sel;
      logic       clr_pressed;
      logic       rel_idx;
      logic       intr;
      logic       activate;
      logic       set_pressed;
      logic       tap;
      logic       rchk;
      logic       scan_clr;
      logic       scan_next;
      logic       scan_rel;
      logic       tmo;
      logic       emit;
      act_type    act;
      logic       cons;
      logic       unm;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic kind;
      logic injected;
      logic is_pr;
      logic was_pr;
      logic td;
      logic masked;
      logic active;
      logic same;
      logic trig_idx;
      logic scan_done;
      logic scan_pend;
      logic tmo_due;
      logic emit_ok;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tap_dance_key_sequencer.sv =====
// Key event: decode, optional interrupt and mask, activation, tap or hold or a
// release check, then verdict, before the next request can be taken.
// Cycle end: the release scan walks the tap count memory one key per cycle,
// pausing to emit each pending release (responses wait on rsp_tready), then a timeout check.
// One request in flight; results leave through a single output register.
// Synchronous reset clears all key state at once; tap counts read as zero.
`default_nettype none

module tap_dance_key_sequencer #(
   parameter int NUM_KEYS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request: tdata = now_ms, is_tap_dance, key_index, row, col, down_now,
   //          down_prev, injected, key_masked (lowest bit first)
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [tds_pkg::IN_DATA_W-1:0] req_tdata,
   // tuser = kind
   input  wire logic [0:0]                    req_tuser,
   // response: tdata = key_index_res, taps, row_res, col_res, consumed,
   //           unmask (lowest bit first)
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [tds_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   // tuser = action
   output logic [tds_pkg::ACT_W-1:0]          rsp_tuser,
   output logic                               rsp_tlast,
   // timeout_ms register write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tds_pkg::TMO_W-1:0]     csr_data
);

   tds_pkg::cmd_type    cmd;
   tds_pkg::status_type st;
   logic                csr_wr;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   tds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   tds_dp #(
      .NUM_KEYS (NUM_KEYS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wr     (csr_wr),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/tds_dp.sv =====
// Datapath of the tap-dance sequencer: request capture, key state, tap count
// memory, release scan counter and response register. Uses tds_pkg.
`default_nettype none
`include "tap_dance_key_sequencer_defines.svh"

module tds_dp #(
   parameter int NUM_KEYS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [tds_pkg::IN_DATA_W-1:0]    req_tdata,
   input  wire logic [0:0]                       req_tuser,
   input  wire logic                             csr_wr,
   input  wire logic [tds_pkg::TMO_W-1:0]        csr_data,
   input  wire tds_pkg::cmd_type                 cmd,
   output tds_pkg::status_type                   st,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [tds_pkg::OUT_DATA_W-1:0]        rsp_tdata,
   output logic [tds_pkg::ACT_W-1:0]             rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CNT_W = $clog2(NUM_KEYS + 1);
   localparam int KW    = tds_pkg::KEY_W;
   localparam int TW    = tds_pkg::TC_W;
   localparam int PW    = tds_pkg::POS_W;
   localparam int NW    = tds_pkg::TIME_W;

   // captured request
   logic          in_kind_ff, in_td_ff, in_is_ff, in_was_ff, in_inj_ff, in_mask_ff;
   logic [NW-1:0] in_now_ff;
   logic [KW-1:0] in_key_ff;
   logic [PW-1:0] in_row_ff, in_col_ff;

   // key state
   logic [tds_pkg::TMO_W-1:0] timeout_ff, timeout_in;
   logic [NW-1:0]       deadline_ff, deadline_in;
   logic [NUM_KEYS-1:0] pressed_ff, pressed_in;
   logic [NUM_KEYS-1:0] trig_ff, trig_in;
   logic [NUM_KEYS-1:0] relpend_ff, relpend_in;
   logic                active_ff, active_in;
   logic [KW-1:0]       act_idx_ff, act_idx_in;
   logic [PW-1:0]       act_row_ff, act_row_in;
   logic [PW-1:0]       act_col_ff, act_col_in;
   logic [CNT_W-1:0]    scan_cnt_ff, scan_cnt_in;

   // tap count memory with per-entry valid bits
   logic [TW-1:0]       tc_mem_ff [NUM_KEYS];
   logic [NUM_KEYS-1:0] tc_vld_ff, tc_vld_in;
   logic [TW-1:0]       tc_rd_ff;
   logic                tc_rv_ff;
   logic [TW-1:0]       tc_rd, tc_inc;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [tds_pkg::ACT_W-1:0] rsp_act_ff;
   logic [KW-1:0]       rsp_key_ff;
   logic [TW-1:0]       rsp_tc_ff;
   logic [PW-1:0]       rsp_row_ff, rsp_col_ff;
   logic                rsp_cons_ff, rsp_unm_ff, rsp_last_ff;

   logic [IDX_W-1:0]    key_ix, ai_ix, scan_ix, rd_ix, rel_ix;
   logic                rel_en;
   logic                emit_ok;

   assign key_ix  = in_key_ff[IDX_W-1:0];
   assign ai_ix   = act_idx_ff[IDX_W-1:0];
   assign scan_ix = scan_cnt_ff[IDX_W-1:0];
   assign tc_rd   = tc_rv_ff ? tc_rd_ff : '0;
   assign tc_inc  = tc_rd + TW'(1);
   assign emit_ok = !rsp_valid_ff || rsp_tready;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_kind_ff <= req_tuser[0];
         in_now_ff  <= req_tdata[tds_pkg::NOW_LSB +: NW];
         in_td_ff   <= req_tdata[tds_pkg::TD_BIT] &&
                       (int'(req_tdata[tds_pkg::KEY_LSB +: KW]) < NUM_KEYS);
         in_key_ff  <= req_tdata[tds_pkg::KEY_LSB +: KW];
         in_row_ff  <= req_tdata[tds_pkg::ROW_LSB +: PW];
         in_col_ff  <= req_tdata[tds_pkg::COL_LSB +: PW];
         in_is_ff   <= req_tdata[tds_pkg::IS_BIT];
         in_was_ff  <= req_tdata[tds_pkg::WAS_BIT];
         in_inj_ff  <= req_tdata[tds_pkg::INJ_BIT];
         in_mask_ff <= req_tdata[tds_pkg::MASKED_BIT];
      end
   end

   // memory read address
   always_comb begin
      case (cmd.rd_sel)
         tds_pkg::RD_ACT:  rd_ix = ai_ix;
         tds_pkg::RD_SCAN: rd_ix = scan_ix;
         default:          rd_ix = key_ix;
      endcase
   end

   // which key, if any, is released this cycle
   always_comb begin
      rel_en = 1'b0;
      rel_ix = key_ix;
      if (cmd.rel_idx) begin
         rel_en = 1'b1;
      end
      if (cmd.rchk && (tc_rd != '0)) begin
         rel_en = 1'b1;
      end
      if ((cmd.intr || cmd.tmo) && !pressed_ff[ai_ix]) begin
         rel_en = 1'b1;
         rel_ix = ai_ix;
      end
   end

   // key state next values
   always_comb begin
      timeout_in  = csr_wr ? csr_data : timeout_ff;
      deadline_in = deadline_ff;
      pressed_in  = pressed_ff;
      trig_in     = trig_ff;
      relpend_in  = relpend_ff;
      active_in   = active_ff;
      act_idx_in  = act_idx_ff;
      act_row_in  = act_row_ff;
      act_col_in  = act_col_ff;
      tc_vld_in   = tc_vld_ff;

      if (cmd.clr_pressed) begin
         pressed_in[key_ix] = 1'b0;
      end
      // interrupt or timeout marks the active key triggered
      if (cmd.intr || cmd.tmo) begin
         trig_in[ai_ix] = 1'b1;
      end
      if (cmd.intr) begin
         deadline_in = '0;
      end
      // new active key
      if (cmd.activate) begin
         active_in  = 1'b1;
         act_idx_in = in_key_ff;
         act_row_in = in_row_ff;
         act_col_in = in_col_ff;
         if (cmd.set_pressed) begin
            pressed_in[key_ix] = 1'b1;
         end
      end
      if (cmd.tap) begin
         deadline_in     = in_now_ff + NW'(timeout_ff);
         tc_vld_in[ai_ix] = 1'b1;
      end
      if (cmd.scan_rel) begin
         relpend_in[scan_ix] = 1'b0;
         tc_vld_in[scan_ix]  = 1'b0;
      end
      // release ends the sequence and queues the key for the next cycle end
      if (rel_en) begin
         deadline_in        = '0;
         active_in          = 1'b0;
         pressed_in[rel_ix] = 1'b0;
         trig_in[rel_ix]    = 1'b0;
         relpend_in[rel_ix] = 1'b1;
      end
   end

   // release scan counter
   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      if (cmd.scan_clr) begin
         scan_cnt_in = '0;
      end else if (cmd.scan_next) begin
         scan_cnt_in = scan_cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= tds_pkg::TMO_RESET;
         deadline_ff <= '0;
         pressed_ff  <= '0;
         trig_ff     <= '0;
         relpend_ff  <= '0;
         active_ff   <= 1'b0;
         act_idx_ff  <= '0;
         act_row_ff  <= '0;
         act_col_ff  <= '0;
         scan_cnt_ff <= '0;
         tc_vld_ff   <= '0;
      end else begin
         timeout_ff  <= timeout_in;
         deadline_ff <= deadline_in;
         pressed_ff  <= pressed_in;
         trig_ff     <= trig_in;
         relpend_ff  <= relpend_in;
         active_ff   <= active_in;
         act_idx_ff  <= act_idx_in;
         act_row_ff  <= act_row_in;
         act_col_ff  <= act_col_in;
         scan_cnt_ff <= scan_cnt_in;
         tc_vld_ff   <= tc_vld_in;
      end
   end

   // tap count memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.tap) begin
         tc_mem_ff[ai_ix] <= tc_inc;
      end
      tc_rd_ff <= tc_mem_ff[rd_ix];
      tc_rv_ff <= tc_vld_ff[rd_ix];
   end

   // response register
   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_act_ff  <= cmd.act;
         rsp_cons_ff <= cmd.cons;
         rsp_unm_ff  <= cmd.unm;
         rsp_last_ff <= (cmd.act == tds_pkg::ACT_VERDICT);
         case (cmd.act)
            tds_pkg::ACT_TAP: begin
               rsp_key_ff <= act_idx_ff;
               rsp_tc_ff  <= tc_inc;
               rsp_row_ff <= act_row_ff;
               rsp_col_ff <= act_col_ff;
            end
            tds_pkg::ACT_RELEASE: begin
               rsp_key_ff <= KW'(scan_ix);
               rsp_tc_ff  <= tc_rd;
               rsp_row_ff <= act_row_ff;
               rsp_col_ff <= act_col_ff;
            end
            tds_pkg::ACT_MASK: begin
               rsp_key_ff <= '0;
               rsp_tc_ff  <= '0;
               rsp_row_ff <= in_row_ff;
               rsp_col_ff <= in_col_ff;
            end
            tds_pkg::ACT_HOLD, tds_pkg::ACT_INTERRUPT, tds_pkg::ACT_TIMEOUT: begin
               rsp_key_ff <= act_idx_ff;
               rsp_tc_ff  <= tc_rd;
               rsp_row_ff <= act_row_ff;
               rsp_col_ff <= act_col_ff;
            end
            default: begin
               rsp_key_ff <= '0;
               rsp_tc_ff  <= '0;
               rsp_row_ff <= '0;
               rsp_col_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_act_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_unm_ff, rsp_cons_ff, rsp_col_ff, rsp_row_ff,
                        rsp_tc_ff, rsp_key_ff};

   // status to the controller
   always_comb begin
      st.kind      = in_kind_ff;
      st.injected  = in_inj_ff;
      st.is_pr     = in_is_ff;
      st.was_pr    = in_was_ff;
      st.td        = in_td_ff;
      st.masked    = in_mask_ff;
      st.active    = active_ff;
      st.same      = (act_idx_ff == in_key_ff);
      st.trig_idx  = trig_ff[key_ix];
      st.scan_done = (scan_cnt_ff == CNT_W'(NUM_KEYS));
      st.scan_pend = relpend_ff[scan_ix];
      st.tmo_due   = active_ff && (deadline_ff != '0) && (in_now_ff > deadline_ff);
      st.emit_ok   = emit_ok;
   end

   `TDS_ASSERT_NEXT(a_tap_sets_valid, cmd.tap, tc_vld_ff[ai_ix])
   `TDS_ASSERT_IMPL(a_scan_only_pending, cmd.scan_rel, relpend_ff[scan_ix])
   `TDS_ASSERT_NEXT(a_tmo_free_release, cmd.tmo && !pressed_ff[ai_ix], !active_ff && relpend_ff[ai_ix])

endmodule

`default_nettype wire

// ===== hw/rtl/tds_ctrl.sv =====
// Controller of the tap-dance sequencer: decodes each request and steps
// through its actions one response at a time. Uses tds_pkg.
`default_nettype none
`include "tap_dance_key_sequencer_defines.svh"

module tds_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire tds_pkg::status_type   st,
   output tds_pkg::cmd_type           cmd
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'h0001,
      S_DECODE    = 13'h0002,
      S_INTR      = 13'h0004,
      S_MASK      = 13'h0008,
      S_ACT       = 13'h0010,
      S_TAP       = 13'h0020,
      S_HOLD      = 13'h0040,
      S_RCHK      = 13'h0080,
      S_SCAN      = 13'h0100,
      S_SCAN_EMIT = 13'h0200,
      S_TCHK      = 13'h0400,
      S_TMO       = 13'h0800,
      S_VERDICT   = 13'h1000
   } state_type;

   state_type state_ff, state_in;

   // plan of the current key event
   logic intr_ff, intr_in;
   logic act_ff, act_in;
   logic setp_ff, setp_in;
   logic tap_ff, tap_in;
   logic hold_ff, hold_in;
   logic rchk_ff, rchk_in;
   logic cons_ff, cons_in;
   logic unm_ff, unm_in;

   logic key_on, key_off, key_held;

   assign key_on   = st.is_pr && !st.was_pr;
   assign key_off  = !st.is_pr && st.was_pr;
   assign key_held = st.is_pr && st.was_pr;

   always_comb begin
      state_in   = state_ff;
      intr_in    = intr_ff;
      act_in     = act_ff;
      setp_in    = setp_ff;
      tap_in     = tap_ff;
      hold_in    = hold_ff;
      rchk_in    = rchk_ff;
      cons_in    = cons_ff;
      unm_in     = unm_ff;
      cmd        = '0;
      cmd.rd_sel = tds_pkg::RD_IDX;
      cmd.act    = tds_pkg::ACT_VERDICT;
      req_tready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end

         // classify the request and record what follows
         S_DECODE: begin
            intr_in = 1'b0;
            act_in  = 1'b0;
            setp_in = 1'b0;
            tap_in  = 1'b0;
            hold_in = 1'b0;
            rchk_in = 1'b0;
            cons_in = 1'b0;
            unm_in  = 1'b0;
            if (st.kind) begin
               cmd.scan_clr = 1'b1;
               state_in     = S_SCAN;
            end else begin
               if (st.injected) begin
                  cons_in = 1'b0;
               end else if (!st.is_pr && !st.was_pr) begin
                  cons_in = st.td;
               end else if (!st.td) begin
                  // plain key: interrupts a running sequence on press; a masked one is consumed
                  if (st.active) begin
                     if (key_on) begin
                        intr_in = 1'b1;
                        cons_in = 1'b1;
                        unm_in  = 1'b1;
                     end else if (st.masked) begin
                        cons_in = 1'b1;
                        unm_in  = 1'b1;
                     end
                  end
               end else begin
                  cons_in         = 1'b1;
                  cmd.clr_pressed = key_off;
                  if (st.active && st.same) begin
                     if (!key_off) begin
                        act_in  = 1'b1;
                        setp_in = 1'b1;
                        tap_in  = key_on;
                        hold_in = key_held && st.trig_idx;
                     end
                  end else if (!st.active) begin
                     if (st.trig_idx) begin
                        cmd.rel_idx = key_off;
                     end else begin
                        act_in = 1'b1;
                        tap_in = 1'b1;
                     end
                  end else if (key_off) begin
                     rchk_in = 1'b1;
                  end else if (key_on) begin
                     intr_in = 1'b1;
                     act_in  = 1'b1;
                     setp_in = 1'b1;
                     tap_in  = 1'b1;
                  end
               end
               cmd.rd_sel = intr_in ? tds_pkg::RD_ACT : tds_pkg::RD_IDX;
               if (intr_in) begin
                  state_in = S_INTR;
               end else if (rchk_in) begin
                  state_in = S_RCHK;
               end else if (act_in) begin
                  state_in = S_ACT;
               end else begin
                  state_in = S_VERDICT;
               end
            end
         end

         S_INTR: begin
            cmd.rd_sel = tds_pkg::RD_ACT;
            cmd.act    = tds_pkg::ACT_INTERRUPT;
            if (st.emit_ok) begin
               cmd.emit = 1'b1;
               cmd.intr = 1'b1;
               state_in = S_MASK;
            end
         end

         S_MASK: begin
            cmd.act = tds_pkg::ACT_MASK;
            if (st.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = act_ff ? S_ACT : S_VERDICT;
            end
         end

         // take over the active key; its tap count is read meanwhile
         S_ACT: begin
            cmd.activate    = 1'b1;
            cmd.set_pressed = setp_ff;
            if (tap_ff) begin
               state_in = S_TAP;
            end else if (hold_ff) begin
               state_in = S_HOLD;
            end else begin
               state_in = S_VERDICT;
            end
         end

         S_TAP: begin
            cmd.act = tds_pkg::ACT_TAP;
            if (st.emit_ok) begin
               cmd.emit = 1'b1;
               cmd.tap  = 1'b1;
               state_in = S_VERDICT;
            end
         end

         S_HOLD: begin
            cmd.act = tds_pkg::ACT_HOLD;
            if (st.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = S_VERDICT;
            end
         end

         S_RCHK: begin
            cmd.rchk = 1'b1;
            state_in = S_VERDICT;
         end

         // cycle end: walk the release-pending keys
         S_SCAN: begin
            cmd.rd_sel = tds_pkg::RD_SCAN;
            if (st.scan_done) begin
               state_in = S_TCHK;
            end else if (st.scan_pend) begin
               state_in = S_SCAN_EMIT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end

         S_SCAN_EMIT: begin
            cmd.rd_sel = tds_pkg::RD_SCAN;
            cmd.act    = tds_pkg::ACT_RELEASE;
            if (st.emit_ok) begin
               cmd.emit      = 1'b1;
               cmd.scan_rel  = 1'b1;
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN;
            end
         end

         S_TCHK: begin
            cmd.rd_sel = tds_pkg::RD_ACT;
            state_in   = st.tmo_due ? S_TMO : S_VERDICT;
         end

         S_TMO: begin
            cmd.rd_sel = tds_pkg::RD_ACT;
            cmd.act    = tds_pkg::ACT_TIMEOUT;
            if (st.emit_ok) begin
               cmd.emit = 1'b1;
               cmd.tmo  = 1'b1;
               state_in = S_VERDICT;
            end
         end

         S_VERDICT: begin
            cmd.act  = tds_pkg::ACT_VERDICT;
            cmd.cons = cons_ff;
            cmd.unm  = unm_ff;
            if (st.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         intr_ff  <= 1'b0;
         act_ff   <= 1'b0;
         setp_ff  <= 1'b0;
         tap_ff   <= 1'b0;
         hold_ff  <= 1'b0;
         rchk_ff  <= 1'b0;
         cons_ff  <= 1'b0;
         unm_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         intr_ff  <= intr_in;
         act_ff   <= act_in;
         setp_ff  <= setp_in;
         tap_ff   <= tap_in;
         hold_ff  <= hold_in;
         rchk_ff  <= rchk_in;
         cons_ff  <= cons_in;
         unm_ff   <= unm_in;
      end
   end

   `TDS_ASSERT_IMPL(a_emit_has_room, cmd.emit, st.emit_ok)
   `TDS_ASSERT_NEXT(a_verdict_ends_item, cmd.emit && (cmd.act == tds_pkg::ACT_VERDICT), state_ff == S_IDLE)

endmodule

`default_nettype wire

// ===== sim/tap_dance_key_sequencer_checker.sv =====
// Checker for the tap-dance key sequencer: tracks key state from accepted requests,
// predicts every action and verdict, and compares them with the response stream.
// Depends on tds_pkg for the request layout and the action codes.
module tap_dance_key_sequencer_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   input  wire logic [tds_pkg::IN_DATA_W-1:0] req_tdata,
   input  wire logic [0:0]                    req_tuser,
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [tds_pkg::OUT_DATA_W-1:0] rsp_tdata,
   input  wire logic [tds_pkg::ACT_W-1:0]     rsp_tuser,
   input  wire logic                          rsp_tlast,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [tds_pkg::TMO_W-1:0]     csr_data,
   output int                                 fail_count,
   output int                                 open_actions
);
   timeunit 1ns;
   timeprecision 1ps;

   // response tdata layout, lowest bit first
   localparam int RSP_KEY_LSB = 0;
   localparam int RSP_CNT_LSB = 4;
   localparam int RSP_ROW_LSB = 12;
   localparam int RSP_COL_LSB = 20;
   localparam int RSP_CONS    = 28;
   localparam int RSP_UNM     = 29;

   typedef struct packed {
      tds_pkg::act_type act;
      logic [3:0]       key;
      logic [7:0]       taps;
      logic [7:0]       row;
      logic [7:0]       col;
      logic             cons;
      logic             unm;
      logic             last;
   } key_action_type;

   key_action_type action_q[$];
   int             mismatches = 0;

   // predicted sequencer state
   logic [15:0] tmo_ms;
   logic [31:0] deadline;
   logic [7:0]  tap_cnt [16];
   logic [15:0] held;
   logic [15:0] fired;
   logic [15:0] rel_due;
   logic        seq_on;
   logic [3:0]  cur_key;
   logic [7:0]  cur_row;
   logic [7:0]  cur_col;

   task automatic push_action(tds_pkg::act_type a, logic [3:0] k, logic [7:0] n,
                              logic [7:0] r, logic [7:0] c);
      action_q.push_back('{a, k, n, r, c, 1'b0, 1'b0, 1'b0});
   endtask

   // key is done: schedule its release for the next cycle end
   task automatic finish_key(logic [3:0] k);
      deadline = '0;
      seq_on   = 1'b0;
      held[k]  = 1'b0;
      fired[k] = 1'b0;
      rel_due[k] = 1'b1;
   endtask

   task automatic take_key(logic [3:0] k, logic [7:0] r, logic [7:0] c);
      seq_on  = 1'b1;
      cur_key = k;
      cur_row = r;
      cur_col = c;
   endtask

   task automatic count_tap(logic [31:0] now);
      tap_cnt[cur_key] = tap_cnt[cur_key] + 8'd1;
      deadline = now + {16'd0, tmo_ms};
      push_action(tds_pkg::ACT_TAP, cur_key, tap_cnt[cur_key], cur_row, cur_col);
   endtask

   // another key pressed: stop the sequence and mask the interrupting key
   task automatic interrupt_seq(logic [7:0] r, logic [7:0] c);
      logic [3:0] k;
      k = cur_key;
      push_action(tds_pkg::ACT_INTERRUPT, k, tap_cnt[k], cur_row, cur_col);
      fired[k] = 1'b1;
      deadline = '0;
      push_action(tds_pkg::ACT_MASK, 4'd0, 8'd0, r, c);
      if (!held[k]) finish_key(k);
   endtask

   // deadline passed; a held key keeps its deadline and times out again
   task automatic expire_seq();
      logic [3:0] k;
      k = cur_key;
      push_action(tds_pkg::ACT_TIMEOUT, k, tap_cnt[k], cur_row, cur_col);
      fired[k] = 1'b1;
      if (!held[k]) finish_key(k);
   endtask

   task automatic scan_end(logic [31:0] now);
      for (int i = 0; i < 16; i++) begin
         if (rel_due[i]) begin
            push_action(tds_pkg::ACT_RELEASE, 4'(i), tap_cnt[i], cur_row, cur_col);
            tap_cnt[i] = 8'd0;
            rel_due[i] = 1'b0;
         end
      end
      if (seq_on && deadline != 0 && now > deadline) expire_seq();
   endtask

   task automatic switch_event(logic [63:0] d, output logic cons, output logic unm);
      logic [31:0] now;
      logic        td;
      logic [3:0]  k;
      logic [7:0]  r;
      logic [7:0]  c;
      logic        is_p;
      logic        was_p;
      logic        msk;
      logic        on;
      logic        off;
      now   = d[tds_pkg::NOW_LSB +: tds_pkg::TIME_W];
      td    = d[tds_pkg::TD_BIT];
      k     = d[tds_pkg::KEY_LSB +: tds_pkg::KEY_W];
      r     = d[tds_pkg::ROW_LSB +: tds_pkg::POS_W];
      c     = d[tds_pkg::COL_LSB +: tds_pkg::POS_W];
      is_p  = d[tds_pkg::IS_BIT];
      was_p = d[tds_pkg::WAS_BIT];
      msk   = d[tds_pkg::MASKED_BIT];
      on    = is_p & ~was_p;
      off   = ~is_p & was_p;
      cons  = 1'b0;
      unm   = 1'b0;
      if (d[tds_pkg::INJ_BIT]) return;
      if (!is_p && !was_p) begin
         cons = td;
         return;
      end
      // plain key: only matters while a sequence runs
      if (!td) begin
         if (!seq_on) return;
         if (on) begin
            interrupt_seq(r, c);
            msk = 1'b1;
         end
         if (msk) begin
            cons = 1'b1;
            unm  = 1'b1;
         end
         return;
      end
      cons = 1'b1;
      if (off) held[k] = 1'b0;
      if (!(seq_on && cur_key == k)) begin
         if (!seq_on) begin
            if (fired[k]) begin
               if (off) finish_key(k);
               return;
            end
            take_key(k, r, c);
            count_tap(now);
            return;
         end
         if (off && tap_cnt[k] != 0) begin
            finish_key(k);
            return;
         end
         if (!on) return;
         interrupt_seq(r, c);
      end
      if (off) return;
      take_key(k, r, c);
      held[k] = 1'b1;
      if (on) begin
         count_tap(now);
         return;
      end
      if (fired[k]) push_action(tds_pkg::ACT_HOLD, k, tap_cnt[k], r, c);
   endtask

   task automatic check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   // predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      key_action_type want;
      logic           cons;
      logic           unm;
      if (reset) begin
         tmo_ms   = tds_pkg::TMO_RESET;
         deadline = '0;
         for (int i = 0; i < 16; i++) tap_cnt[i] = 8'd0;
         held     = '0;
         fired    = '0;
         rel_due  = '0;
         seq_on   = 1'b0;
         cur_key  = '0;
         cur_row  = '0;
         cur_col  = '0;
         action_q.delete();
      end else begin
         if (csr_valid && csr_ready) tmo_ms = csr_data;
         if (req_tvalid && req_tready) begin
            cons = 1'b0;
            unm  = 1'b0;
            if (req_tuser[0]) scan_end(req_tdata[tds_pkg::NOW_LSB +: tds_pkg::TIME_W]);
            else switch_event(req_tdata, cons, unm);
            action_q.push_back('{tds_pkg::ACT_VERDICT, 4'd0, 8'd0, 8'd0, 8'd0, cons, unm,
                                 1'b1});
         end
         if (rsp_tvalid && rsp_tready) begin
            if (action_q.size() == 0) begin
               $display("%0t: response with no request pending, action %0d", $time,
                        rsp_tuser);
               mismatches++;
            end else begin
               want = action_q.pop_front();
               check_field("action", want.act, rsp_tuser);
               check_field("key_index", want.key,
                           rsp_tdata[RSP_KEY_LSB +: tds_pkg::KEY_W]);
               check_field("taps", want.taps, rsp_tdata[RSP_CNT_LSB +: tds_pkg::TC_W]);
               check_field("row", want.row, rsp_tdata[RSP_ROW_LSB +: tds_pkg::POS_W]);
               check_field("col", want.col, rsp_tdata[RSP_COL_LSB +: tds_pkg::POS_W]);
               check_field("consumed", want.cons, rsp_tdata[RSP_CONS]);
               check_field("unmask", want.unm, rsp_tdata[RSP_UNM]);
               check_field("last", want.last, rsp_tlast);
            end
         end
      end
      fail_count   <= mismatches;
      open_actions <= action_q.size();
   end

endmodule

// ===== sim/tap_dance_key_sequencer_tb.sv =====
// Top of the tap-dance key sequencer testbench: clock, reset, request and
// timeout register stimulus, response back-pressure, watchdog and verdict.
// Depends on tds_pkg, tap_dance_key_sequencer and tap_dance_key_sequencer_checker.
module tap_dance_key_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASE_ITEMS  = 27;
   localparam int WRAP_TAPS    = 257;
   localparam int NUM_POS      = 6;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [tds_pkg::IN_DATA_W-1:0]  req_tdata;
   logic [0:0]                     req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [tds_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic [tds_pkg::ACT_W-1:0]      rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [tds_pkg::TMO_W-1:0]      csr_data;
   int                             fail_count;
   int                             open_actions;

   int          idle_cycles = 0;
   int          req_calm = 0;
   int          rsp_calm = 0;
   logic [31:0] now_ms;

   // switch positions used by the random part
   logic        pos_td   [NUM_POS];
   logic [3:0]  pos_key  [NUM_POS];
   logic [7:0]  pos_row  [NUM_POS];
   logic [7:0]  pos_col  [NUM_POS];
   logic        pos_down [NUM_POS];

   always #5 clock = ~clock;

   tap_dance_key_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   tap_dance_key_sequencer_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .open_actions (open_actions)
   );

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // valid stays high across back-to-back requests; lowered only for a gap
   task automatic send_req(logic kind, logic [tds_pkg::IN_DATA_W-1:0] data);
      int gap;
      gap = pick_gap(req_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_key(logic td, logic [3:0] k, logic [7:0] r, logic [7:0] c,
                           logic is_p, logic was_p, logic inj, logic msk);
      logic [tds_pkg::IN_DATA_W-1:0] d;
      d = '0;
      d[tds_pkg::NOW_LSB +: tds_pkg::TIME_W] = now_ms;
      d[tds_pkg::TD_BIT]                     = td;
      d[tds_pkg::KEY_LSB +: tds_pkg::KEY_W]  = k;
      d[tds_pkg::ROW_LSB +: tds_pkg::POS_W]  = r;
      d[tds_pkg::COL_LSB +: tds_pkg::POS_W]  = c;
      d[tds_pkg::IS_BIT]                     = is_p;
      d[tds_pkg::WAS_BIT]                    = was_p;
      d[tds_pkg::INJ_BIT]                    = inj;
      d[tds_pkg::MASKED_BIT]                 = msk;
      send_req(1'b0, d);
   endtask

   task automatic send_cycle_end();
      logic [tds_pkg::IN_DATA_W-1:0] d;
      d = '0;
      d[tds_pkg::NOW_LSB +: tds_pkg::TIME_W] = now_ms;
      send_req(1'b1, d);
   endtask

   // wait for every expected response, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (open_actions != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(logic [tds_pkg::TMO_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed press/hold/release traffic with cycle ends, some noise
   task automatic random_item();
      int          roll;
      int          p;
      logic        is_p;
      logic        was_p;
      logic [63:0] d;
      roll = $urandom_range(0, 99);
      if (roll < 65) now_ms += $urandom_range(0, 20);
      else if (roll < 95) now_ms += $urandom_range(0, 400);
      else now_ms += $urandom_range(0, 200000);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         d = {$urandom, $urandom};
         d[63:57] = '0;
         send_req(1'($urandom_range(0, 1)), d);
      end else if (roll < 40) begin
         send_cycle_end();
      end else begin
         p = $urandom_range(0, NUM_POS - 1);
         was_p = pos_down[p];
         if (was_p) is_p = $urandom_range(0, 9) < 4;
         else is_p = $urandom_range(0, 9) < 8;
         pos_down[p] = is_p;
         send_key(pos_td[p], pos_key[p], pos_row[p], pos_col[p], is_p, was_p,
                  $urandom_range(0, 19) == 0, 1'($urandom_range(0, 1)));
      end
   endtask

   // response back-pressure
   initial begin
      int n;
      forever begin
         n = pick_gap(rsp_calm);
         if (n != 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tap_dance_key_sequencer regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [15:0] timeouts [5];
      timeouts = '{16'd0, 16'd65535, 16'd25, 16'd1, 16'd200};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      now_ms = 32'd1000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part, default timeout of 200 ms
      send_cycle_end();
      send_key(1, 4'd0, 8'd0, 8'd255, 1, 0, 0, 0);      // first tap
      now_ms = 32'd1010;
      send_key(1, 4'd0, 8'd0, 8'd255, 0, 1, 0, 0);
      now_ms = 32'd1020;
      send_key(1, 4'd0, 8'd0, 8'd255, 1, 0, 0, 0);      // second tap
      send_key(1, 4'd0, 8'd0, 8'd255, 1, 1, 0, 0);      // held, not yet triggered
      send_key(1, 4'd15, 8'd255, 8'd0, 1, 0, 0, 0);     // interrupt by other key
      send_key(1, 4'd0, 8'd0, 8'd255, 1, 1, 0, 0);
      send_key(1, 4'd0, 8'd0, 8'd255, 0, 1, 0, 0);      // release of interrupted key
      send_cycle_end();
      now_ms = 32'd5000;
      send_cycle_end();                                 // cycle end, no sequence running
      now_ms = 32'd5001;
      send_cycle_end();                                 // again with no sequence running
      send_key(1, 4'd15, 8'd255, 8'd0, 1, 1, 0, 0);     // key 15 still down starts a new sequence with a tap
      send_key(1, 4'd15, 8'd255, 8'd0, 0, 1, 0, 0);
      send_cycle_end();                                 // cycle end before the deadline, key up
      send_cycle_end();
      send_key(0, 4'd3, 8'h5a, 8'ha5, 1, 0, 0, 0);      // plain key interrupts the sequence of key 15
      send_key(1, 4'd0, 8'd0, 8'd255, 1, 0, 0, 0);
      send_key(0, 4'd3, 8'h5a, 8'ha5, 1, 0, 0, 0);      // plain key interrupts
      send_key(0, 4'd3, 8'h5a, 8'ha5, 1, 1, 0, 1);      // masked plain key held
      send_key(1, 4'd15, 8'd255, 8'd0, 1, 0, 1, 0);     // injected
      send_key(1, 4'd15, 8'd255, 8'd0, 0, 0, 0, 0);     // idle tap-dance key
      send_key(1, 4'd0, 8'd0, 8'd255, 0, 1, 0, 0);
      now_ms = 32'hffff_ff38;
      send_key(1, 4'd0, 8'd0, 8'd255, 1, 0, 0, 0);      // deadline wraps to zero
      now_ms = 32'hffff_ffff;
      send_cycle_end();
      send_key(1, 4'd15, 8'd255, 8'd0, 0, 1, 0, 0);

      // tap count wraps past 255
      repeat (WRAP_TAPS) send_key(1, 4'd0, 8'd0, 8'd255, 1, 0, 0, 0);

      // random phases, one timeout setting each
      foreach (timeouts[t]) begin
         write_timeout(timeouts[t]);
         for (int p = 0; p < NUM_POS; p++) begin
            pos_td[p]   = p < 4;
            pos_key[p]  = 4'($urandom_range(0, 15));
            pos_row[p]  = 8'($urandom_range(0, 255));
            pos_col[p]  = 8'($urandom_range(0, 255));
            pos_down[p] = 1'b0;
         end
         repeat (PHASE_ITEMS) random_item();
      end

      drain();
      if (fail_count == 0) begin
         $display("tap_dance_key_sequencer regression: pass");
      end else begin
         $display("tap_dance_key_sequencer regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tds_pkg.sv
hw/rtl/tds_dp.sv
hw/rtl/tds_ctrl.sv
hw/rtl/tap_dance_key_sequencer.sv
sim/tap_dance_key_sequencer_checker.sv
sim/tap_dance_key_sequencer_tb.sv
